>>> rtl/ecd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecd_pkg: shared types and constants for epoch-seconds to civil date
// Reciprocal constants for the constant divisions, bias offsets and the
// per-stage item record carried down the pipeline.
// ----------------------------------------------------------------------------
package ecd_pkg;

  localparam int unsigned SEC_W = 40;

  localparam longint unsigned SEC_PER_DAY = 86400;
  localparam int unsigned     SOD_LO_W    = 7;
  localparam longint unsigned D_DAY       = SEC_PER_DAY / (64'd1 << SOD_LO_W);
  localparam longint unsigned D_ERA       = 146097;
  localparam longint unsigned D_WEEK      = 7;
  localparam longint unsigned D_4Y        = 1460;
  localparam longint unsigned D_100Y      = 36524;
  localparam longint unsigned D_400Y      = 146096;
  localparam longint unsigned D_YEAR      = 365;
  localparam longint unsigned D_MP        = 153;
  localparam longint unsigned D_60        = 60;

  // floor(x/d) = (x*m) >> k, exact for x < 2^n with k = n + clog2(d), m = ceil(2^k/d)
  localparam int unsigned K_DAYH = 17 + $clog2(D_DAY);
  localparam logic [17:0] M_DAYH = 18'(((64'd1 << K_DAYH) + D_DAY - 1) / D_DAY);
  localparam int unsigned K_DAYL = 27 + $clog2(D_DAY);
  localparam logic [27:0] M_DAYL = 28'(((64'd1 << K_DAYL) + D_DAY - 1) / D_DAY);
  localparam int unsigned K_WEEK = 25 + $clog2(D_WEEK);
  localparam logic [25:0] M_WEEK = 26'(((64'd1 << K_WEEK) + D_WEEK - 1) / D_WEEK);
  localparam int unsigned K_ERA  = 25 + $clog2(D_ERA);
  localparam logic [25:0] M_ERA  = 26'(((64'd1 << K_ERA) + D_ERA - 1) / D_ERA);
  localparam int unsigned K_4Y   = 18 + $clog2(D_4Y);
  localparam logic [18:0] M_4Y   = 19'(((64'd1 << K_4Y) + D_4Y - 1) / D_4Y);
  localparam int unsigned K_100Y = 18 + $clog2(D_100Y);
  localparam logic [18:0] M_100Y = 19'(((64'd1 << K_100Y) + D_100Y - 1) / D_100Y);
  localparam int unsigned K_400Y = 18 + $clog2(D_400Y);
  localparam logic [18:0] M_400Y = 19'(((64'd1 << K_400Y) + D_400Y - 1) / D_400Y);
  localparam int unsigned K_YEAR = 18 + $clog2(D_YEAR);
  localparam logic [18:0] M_YEAR = 19'(((64'd1 << K_YEAR) + D_YEAR - 1) / D_YEAR);
  localparam int unsigned K_MP   = 11 + $clog2(D_MP);
  localparam logic [11:0] M_MP   = 12'(((64'd1 << K_MP) + D_MP - 1) / D_MP);
  localparam int unsigned K_MINS = 17 + $clog2(D_60);
  localparam logic [17:0] M_MINS = 18'(((64'd1 << K_MINS) + D_60 - 1) / D_60);
  localparam int unsigned K_HRS  = 11 + $clog2(D_60);
  localparam logic [11:0] M_HRS  = 12'(((64'd1 << K_HRS) + D_60 - 1) / D_60);

  // biases that keep every dividend non-negative
  localparam longint unsigned DAY_BIAS  = 64'd1 << 23;
  localparam logic [33:0]     U_OFF     = 34'(D_DAY * DAY_BIAS);
  localparam longint unsigned ERA_BIAS  = 64;
  localparam longint unsigned SHIFT_DAYS = 719468;
  localparam logic [24:0]     Z_OFF     = 25'(SHIFT_DAYS + ERA_BIAS * D_ERA - DAY_BIAS);
  localparam logic [16:0]     YEAR_BIAS = 17'(ERA_BIAS * 400);
  localparam logic [3:0]      WD_ADJ    = 4'((4 + D_WEEK - (DAY_BIAS % D_WEEK)) % D_WEEK);

  // March-based month index of January, and day offsets around it
  localparam logic [3:0] MP_JAN  = 4'd10;
  localparam logic [8:0] DOY_JAN = 9'd306;
  localparam logic [8:0] FEB_END = 9'd59;

  typedef struct packed {
    logic [6:0]         r7;
    logic [33:0]        u;
    logic [7:0]         qh;
    logic [26:0]        x2;
    logic [16:0]        ql;
    logic [16:0]        sod;
    logic [24:0]        day_u;
    logic [24:0]        zp;
    logic [21:0]        wq;
    logic [2:0]         wd;
    logic [6:0]         era_u;
    logic [17:0]        doe;
    logic [15:0]        ybase;
    logic [6:0]         q4y;
    logic [2:0]         q100y;
    logic               q400y;
    logic [17:0]        t;
    logic [8:0]         yoe;
    logic [17:0]        yd;
    logic               leap;
    logic [8:0]         doy;
    logic [3:0]         mp;
    logic [10:0]        mins;
    logic [5:0]         sec;
    logic [4:0]         hr;
    logic [5:0]         mn;
    logic signed [15:0] year;
    logic [3:0]         month;
    logic [4:0]         mday;
    logic [8:0]         yday;
  } item_t;

  // first March-based day of each month: (153*mp + 2) / 5
  function automatic logic [8:0] mon_start(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // leap test on year of era; the era itself is a multiple of 400 years
  function automatic logic is_leap_yoe(input logic [8:0] yoe);
    return (yoe[1:0] == 2'b00) && (yoe != 9'd100) && (yoe != 9'd200) && (yoe != 9'd300);
  endfunction

endpackage
`default_nettype wire

>>> rtl/ecd_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecd_in_if: timestamp channel
// Valid/ready channel carrying one signed epoch-seconds value per transfer.
// ----------------------------------------------------------------------------
interface ecd_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [ecd_pkg::SEC_W-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface
`default_nettype wire

>>> rtl/ecd_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecd_out_if: civil date channel
// Valid/ready channel carrying one broken-down date and time per transfer.
// ----------------------------------------------------------------------------
interface ecd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] year;
  logic [3:0]         month;
  logic [4:0]         day_of_month;
  logic [4:0]         hour;
  logic [5:0]         minute;
  logic [5:0]         second;
  logic [2:0]         weekday;
  logic [8:0]         day_of_year;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, output weekday,
                  output day_of_year, input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input hour, input minute, input second, input weekday,
                  input day_of_year, output ready);
endinterface
`default_nettype wire

>>> rtl/epoch_seconds_to_civil_date.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_seconds_to_civil_date: seconds since 1970-01-01 UTC to civil date
// Floors the timestamp into days and second of day, then splits the day
// count into 400-year eras, year of era and March-based day, all by
// reciprocal multiplication.
//
//   channel  dir  payload
//   secs     in   epoch_seconds
//   date     out  year, month, day_of_month, hour, minute, second,
//                 weekday, day_of_year
//
// 15-stage pipeline: one transfer per cycle while the date channel is not stalled.
// The depth is set by the chain of dependent constant divisions of the date.
// Reset clears the stage valid bits only.
// Each stage holds while its successor is full and stalled; empty stages
// fill behind a stalled output, so bubbles collapse.
// ----------------------------------------------------------------------------
module epoch_seconds_to_civil_date (
  input  wire logic clk,
  input  wire logic rst,
  ecd_in_if.sink    secs,
  ecd_out_if.source date
);

  localparam int unsigned NSTG = 15;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;
  ecd_pkg::item_t  pipe [NSTG];
  ecd_pkg::item_t  nxt  [NSTG];

  assign en[NSTG-1] = !vld[NSTG-1] || date.ready;
  for (genvar g = 0; g < NSTG - 1; g++) begin : g_en
    assign en[g] = !vld[g] || en[g+1];
  end

  assign secs.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= secs.valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NSTG; i++) begin
      if (en[i]) begin
        pipe[i] <= nxt[i];
      end
    end
  end

  always_comb begin
    logic [34:0] p_qh;
    logic [54:0] p_ql;
    logic [50:0] p_wq;
    logic [50:0] p_era;
    logic [36:0] p_4y;
    logic [36:0] p_100y;
    logic [36:0] p_400y;
    logic [36:0] p_yr;
    logic [22:0] p_mp;
    logic [34:0] p_min;
    logic [22:0] p_hr;
    logic [9:0]  rh;
    logic [9:0]  rl;
    logic [2:0]  wmod;
    logic [3:0]  wraw;
    logic [1:0]  q100;
    logic [10:0] mp_arg;
    logic [16:0] yr_sum;
    logic        late;

    // floor(s / 128) biased positive, low seconds kept
    nxt[0]    = pipe[0];
    nxt[0].r7 = secs.epoch_seconds[6:0];
    nxt[0].u  = {secs.epoch_seconds[39], secs.epoch_seconds[39:7]} + ecd_pkg::U_OFF;

    // long division by 675, high digit
    nxt[1]    = pipe[0];
    p_qh      = 35'(pipe[0].u[33:17]) * 35'(ecd_pkg::M_DAYH);
    nxt[1].qh = 8'(p_qh >> ecd_pkg::K_DAYH);

    nxt[2]    = pipe[1];
    rh        = 10'(pipe[1].u[33:17] - 17'(17'(pipe[1].qh) * 17'(ecd_pkg::D_DAY)));
    nxt[2].x2 = {rh, pipe[1].u[16:0]};

    // low digit
    nxt[3]    = pipe[2];
    p_ql      = 55'(pipe[2].x2) * 55'(ecd_pkg::M_DAYL);
    nxt[3].ql = 17'(p_ql >> ecd_pkg::K_DAYL);

    nxt[4]       = pipe[3];
    rl           = 10'(pipe[3].x2 - 27'(27'(pipe[3].ql) * 27'(ecd_pkg::D_DAY)));
    nxt[4].sod   = {rl, pipe[3].r7};
    nxt[4].day_u = {pipe[3].qh, pipe[3].ql};

    nxt[5]      = pipe[4];
    nxt[5].zp   = pipe[4].day_u + ecd_pkg::Z_OFF;
    p_wq        = 51'(pipe[4].day_u) * 51'(ecd_pkg::M_WEEK);
    nxt[5].wq   = 22'(p_wq >> ecd_pkg::K_WEEK);
    p_min       = 35'(pipe[4].sod) * 35'(ecd_pkg::M_MINS);
    nxt[5].mins = 11'(p_min >> ecd_pkg::K_MINS);

    nxt[6]       = pipe[5];
    p_era        = 51'(pipe[5].zp) * 51'(ecd_pkg::M_ERA);
    nxt[6].era_u = 7'(p_era >> ecd_pkg::K_ERA);
    wmod         = 3'(pipe[5].day_u - 25'(25'(pipe[5].wq) * 25'(ecd_pkg::D_WEEK)));
    wraw         = {1'b0, wmod} + ecd_pkg::WD_ADJ;
    nxt[6].wd    = (wraw >= 4'(ecd_pkg::D_WEEK)) ? 3'(wraw - 4'(ecd_pkg::D_WEEK)) : 3'(wraw);
    nxt[6].sec   = 6'(pipe[5].sod - 17'(17'(pipe[5].mins) * 17'(ecd_pkg::D_60)));
    p_hr         = 23'(pipe[5].mins) * 23'(ecd_pkg::M_HRS);
    nxt[6].hr    = 5'(p_hr >> ecd_pkg::K_HRS);

    nxt[7]       = pipe[6];
    nxt[7].doe   = 18'(pipe[6].zp - 25'(25'(pipe[6].era_u) * 25'(ecd_pkg::D_ERA)));
    nxt[7].ybase = 16'(16'(pipe[6].era_u) * 16'd400);
    nxt[7].mn    = 6'(pipe[6].mins - 11'(11'(pipe[6].hr) * 11'(ecd_pkg::D_60)));

    nxt[8]       = pipe[7];
    p_4y         = 37'(pipe[7].doe) * 37'(ecd_pkg::M_4Y);
    p_100y       = 37'(pipe[7].doe) * 37'(ecd_pkg::M_100Y);
    p_400y       = 37'(pipe[7].doe) * 37'(ecd_pkg::M_400Y);
    nxt[8].q4y   = 7'(p_4y >> ecd_pkg::K_4Y);
    nxt[8].q100y = 3'(p_100y >> ecd_pkg::K_100Y);
    nxt[8].q400y = 1'(p_400y >> ecd_pkg::K_400Y);

    nxt[9]   = pipe[8];
    nxt[9].t = pipe[8].doe - 18'(pipe[8].q4y) + 18'(pipe[8].q100y) - 18'(pipe[8].q400y);

    nxt[10]     = pipe[9];
    p_yr        = 37'(pipe[9].t) * 37'(ecd_pkg::M_YEAR);
    nxt[10].yoe = 9'(p_yr >> ecd_pkg::K_YEAR);

    nxt[11]      = pipe[10];
    q100         = 2'(pipe[10].yoe >= 9'd100) + 2'(pipe[10].yoe >= 9'd200)
                 + 2'(pipe[10].yoe >= 9'd300);
    nxt[11].yd   = 18'(18'(pipe[10].yoe) * 18'(ecd_pkg::D_YEAR))
                 + 18'(pipe[10].yoe[8:2]) - 18'(q100);
    nxt[11].leap = ecd_pkg::is_leap_yoe(pipe[10].yoe);

    nxt[12]     = pipe[11];
    nxt[12].doy = 9'(pipe[11].doe - pipe[11].yd);

    nxt[13]    = pipe[12];
    mp_arg     = 11'({pipe[12].doy, 2'b00}) + 11'(pipe[12].doy) + 11'd2;
    p_mp       = 23'(mp_arg) * 23'(ecd_pkg::M_MP);
    nxt[13].mp = 4'(p_mp >> ecd_pkg::K_MP);

    nxt[14]       = pipe[13];
    late          = pipe[13].mp >= ecd_pkg::MP_JAN;
    yr_sum        = 17'(pipe[13].ybase) + 17'(pipe[13].yoe) + 17'(late) - ecd_pkg::YEAR_BIAS;
    nxt[14].year  = 16'(yr_sum);
    nxt[14].month = late ? 4'(pipe[13].mp - ecd_pkg::MP_JAN) : 4'(pipe[13].mp + 4'd2);
    nxt[14].mday  = 5'(pipe[13].doy - ecd_pkg::mon_start(pipe[13].mp) + 9'd1);
    nxt[14].yday  = late ? 9'(pipe[13].doy - ecd_pkg::DOY_JAN)
                         : 9'(pipe[13].doy + ecd_pkg::FEB_END + 9'(pipe[13].leap));
  end

  assign date.valid        = vld[NSTG-1];
  assign date.year         = pipe[NSTG-1].year;
  assign date.month        = pipe[NSTG-1].month;
  assign date.day_of_month = pipe[NSTG-1].mday;
  assign date.hour         = pipe[NSTG-1].hr;
  assign date.minute       = pipe[NSTG-1].mn;
  assign date.second       = pipe[NSTG-1].sec;
  assign date.weekday      = pipe[NSTG-1].wd;
  assign date.day_of_year  = pipe[NSTG-1].yday;

endmodule
`default_nettype wire

>>> tb/epoch_seconds_to_civil_date_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_seconds_to_civil_date_tb: self-checking bench for the date converter
// Drives signed 40-bit timestamps over the secs channel. The directed ones
// cover field extremes, day and leap boundaries and negative times. The
// random ones are spread over the full range, near the epoch, on day edges
// and on era edges. Every transfer is predicted by an independent floor-division
// calendar model and each date transfer is compared field by field. Both
// channels throttle at random, and there is one long output hold-off and
// three full drains.
// ----------------------------------------------------------------------------
module epoch_seconds_to_civil_date_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_ITEMS = 630;
  localparam int          PIPE_LATENCY = 15;
  localparam int          HOLD_CYCLES  = 100;
  localparam int          BURST_ITEMS  = 60;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  localparam longint SECS_PER_DAY = 86400;
  localparam longint MARCH_SHIFT  = 719468;
  localparam longint ERA_LEN      = 146097;

  typedef logic signed [ecd_pkg::SEC_W-1:0] stamp_t;

  typedef struct packed {
    logic signed [15:0] year;
    logic [3:0]         month;
    logic [4:0]         day_of_month;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [2:0]         weekday;
    logic [8:0]         day_of_year;
  } civil_t;

  class civil_date_scoreboard;
    civil_t expected_dates[$];
    int     errors = 0;

    function civil_t to_civil(stamp_t ts);
      longint s, days, sod, z, era, doe, yoe, y, doy_mar, mp, mon1, yday, wd;
      bit     leap;
      civil_t c;
      s    = ts;
      days = s / SECS_PER_DAY;
      sod  = s % SECS_PER_DAY;
      if (sod < 0) begin
        sod  += SECS_PER_DAY;
        days -= 1;
      end
      z       = days + MARCH_SHIFT;
      era     = (z >= 0 ? z : z - (ERA_LEN - 1)) / ERA_LEN;
      doe     = z - era * ERA_LEN;
      yoe     = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      y       = yoe + era * 400;
      doy_mar = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp      = (5 * doy_mar + 2) / 153;
      mon1    = mp < 10 ? mp + 3 : mp - 9;
      if (mon1 <= 2) y += 1;
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      yday = (mon1 <= 2) ? doy_mar - 306 : doy_mar + 59 + (leap ? 1 : 0);
      wd   = days % 7;
      if (wd < 0) wd += 7;
      wd = (wd + 4) % 7;
      c.year         = 16'(y);
      c.month        = 4'(mon1 - 1);
      c.day_of_month = 5'(doy_mar - (153 * mp + 2) / 5 + 1);
      c.hour         = 5'(sod / 3600);
      c.minute       = 6'((sod % 3600) / 60);
      c.second       = 6'(sod % 60);
      c.weekday      = 3'(wd);
      c.day_of_year  = 9'(yday);
      return c;
    endfunction

    function void note_timestamp(stamp_t ts);
      expected_dates.push_back(to_civil(ts));
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_date(civil_t got);
      civil_t want;
      if (expected_dates.size() == 0) begin
        $error("date transfer with no timestamp outstanding");
        errors++;
        return;
      end
      want = expected_dates.pop_front();
      compare_field("year", want.year, got.year);
      compare_field("month", want.month, got.month);
      compare_field("day_of_month", want.day_of_month, got.day_of_month);
      compare_field("hour", want.hour, got.hour);
      compare_field("minute", want.minute, got.minute);
      compare_field("second", want.second, got.second);
      compare_field("weekday", want.weekday, got.weekday);
      compare_field("day_of_year", want.day_of_year, got.day_of_year);
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  bit          hold_off_req = 1'b0;
  int unsigned cycle_count = 0;

  civil_date_scoreboard board = new();

  ecd_in_if  secs_if();
  ecd_out_if date_if();

  epoch_seconds_to_civil_date dut (
    .clk  (clk),
    .rst  (rst),
    .secs (secs_if),
    .date (date_if)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic stamp_t random_stamp();
    int     r;
    longint v, d;
    r = $urandom_range(99);
    if (r < 35) begin
      v = {$urandom_range(255), $urandom};
      return stamp_t'(v);
    end else if (r < 70) begin
      v = longint'($urandom) + (longint'($urandom_range(3)) << 32) - (longint'(1) << 33);
    end else if (r < 90) begin
      d = longint'($urandom_range(12000000)) - 6000000;
      case ($urandom_range(4))
        0: v = d * SECS_PER_DAY;
        1: v = d * SECS_PER_DAY + 1;
        2: v = d * SECS_PER_DAY - 1;
        3: v = d * SECS_PER_DAY + 43200;
        default: v = d * SECS_PER_DAY + longint'($urandom_range(86399));
      endcase
    end else begin
      // edges of eras, centuries and leap days in the March-based count
      d = (longint'($urandom_range(78)) - 38) * ERA_LEN - MARCH_SHIFT;
      case ($urandom_range(7))
        0: d += 0;
        1: d -= 1;
        2: d += 59;
        3: d += 60;
        4: d += 365;
        5: d += 36524;
        6: d += 36525;
        default: d += 146096;
      endcase
      v = d * SECS_PER_DAY + longint'($urandom_range(86399));
    end
    return stamp_t'(v);
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_stamp(input stamp_t ts);
    secs_if.valid         <= 1'b1;
    secs_if.epoch_seconds <= ts;
    do @(posedge clk); while (!secs_if.ready);
    board.note_timestamp(ts);
    @(negedge clk);
  endtask

  task automatic idle_input(input int n);
    if (n > 0) begin
      secs_if.valid         <= 1'b0;
      secs_if.epoch_seconds <= stamp_t'({$urandom_range(255), $urandom});
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    while (board.pending() != 0) @(negedge clk);
  endtask

  // output side throttle, with one long hold-off on request
  initial begin
    int n, g;
    date_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        date_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        date_if.ready <= 1'b1;
        n = ($urandom_range(9) == 0) ? $urandom_range(200, 50) : $urandom_range(8, 1);
        do begin
          @(negedge clk);
          n--;
        end while (n > 0 && !hold_off_req);
        if (!hold_off_req) begin
          g = gap_len();
          if (g > 0) date_if.ready <= 1'b0;
          repeat (g) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    civil_t got;
    if (!rst && date_if.valid && date_if.ready) begin
      got.year         = date_if.year;
      got.month        = date_if.month;
      got.day_of_month = date_if.day_of_month;
      got.hour         = date_if.hour;
      got.minute       = date_if.minute;
      got.second       = date_if.second;
      got.weekday      = date_if.weekday;
      got.day_of_year  = date_if.day_of_year;
      board.check_date(got);
    end
  end

  initial begin
    longint directed[$] = '{
      0, -1, 86399, 86400, -86400, -86401,
      951782400, 951868800, 978220800,
      -64'sd2203977600, -64'sd2203891200,
      2147483647, 64'sd2147483648, 64'sd4294967296,
      -64'sd62162121600, -64'sd62162035200, -64'sd62162035201, -64'sd62135596800,
      64'sd253402300799, 64'sd253402300800,
      64'sd549755813887, -64'sd549755813888,
      64'sd366503875925, -64'sd366503875926
    };
    int burst_left, quiet_left;
    secs_if.valid         = 1'b0;
    secs_if.epoch_seconds = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) begin
      idle_input(gap_len());
      send_stamp(stamp_t'(directed[i]));
    end
    idle_input(1);
    drain();

    burst_left = 0;
    quiet_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 200) begin
        hold_off_req = 1'b1;
        burst_left   = BURST_ITEMS;
      end
      if (i == 420) begin
        idle_input(1);
        drain();
      end
      if (i % 128 == 64) quiet_left = 40;
      if (burst_left > 0 || quiet_left > 0) begin
        if (burst_left > 0) burst_left--;
        if (quiet_left > 0) quiet_left--;
      end else begin
        idle_input(gap_len());
      end
      send_stamp(random_stamp());
    end

    idle_input(1);
    drain();
    repeat (PIPE_LATENCY + 10) @(negedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
